>>> rtl/core/lrg_pkg.sv
package lrg_pkg;

    // coordinate width default and fixed field widths
    localparam int COORD_WIDTH_DEF = 13;
    localparam int REG_WIDTH       = 13;
    localparam int PIX_WIDTH       = 14;
    localparam int PCT_WIDTH       = 7;
    localparam int CFG_IDX_WIDTH   = 1;

    // output tdata: pixel_x, pixel_y, percent, padded to whole bytes
    localparam int OUT_USED_W   = 2 * PIX_WIDTH + PCT_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

    // full scale of the progress value
    localparam logic [PCT_WIDTH-1:0] PCT_FULL = 7'd100;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request kinds carried in s_tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_H_OFFSET = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_V_OFFSET = 1'd1;

    // per-pixel control flags passed from front to back
    typedef struct packed {
        logic pix_valid;
        logic zero_q;
        logic inv;
        logic done;
    } lrg_ctrl_t;

endpackage

>>> rtl/core/lrg_queue.sv
module lrg_queue
    import lrg_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/lrg_front.sv
module lrg_front
    import lrg_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF,
    localparam int DW = W + 3,
    localparam int TW = ((4 * W + 7) / 8) * 8,
    localparam int SW = ((W > REG_WIDTH) ? W : REG_WIDTH) + 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [TW-1:0]            s_tdata,
    input  logic                     s_tuser,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [REG_WIDTH-1:0]     cfg_data,
    input  logic                     q_full,
    output logic                     push,
    output lrg_ctrl_t                ctrl,
    output logic [PIX_WIDTH-1:0]     px,
    output logic [PIX_WIDTH-1:0]     py,
    output logic [W:0]               num_mag,
    output logic [W:0]               den_mag
);

    logic signed [REG_WIDTH-1:0] h_off_reg;
    logic signed [REG_WIDTH-1:0] v_off_reg;

    logic signed [W-1:0]  cur_x_reg, cur_y_reg;
    logic signed [W-1:0]  tgt_x_reg, tgt_y_reg;
    logic signed [W-1:0]  org_x_reg, org_y_reg;
    logic signed [DW-1:0] dec_reg, step_e_reg, step_ne_reg;
    logic                 x_major_reg, x_rising_reg, inv_reg;

    logic accept, is_load, is_step;

    // load decode
    logic signed [W-1:0]  ex, ey, sx, sy;
    logic signed [W-1:0]  tx, ty, ox, oy;
    logic                 ld_inv, ld_rising, ld_major;
    logic signed [W:0]    diff_x, ld_dx, ld_dy;
    logic signed [DW-1:0] dx_e, dy_e, dx2, dy2;
    logic signed [DW-1:0] ld_dec, ld_se, ld_sne;

    // step
    logic                 walk, tail, dec_le0;
    logic signed [W-1:0]  xstep;
    logic signed [W-1:0]  cur_x_next, cur_y_next;
    logic signed [DW-1:0] dec_next;
    logic signed [W:0]    num_s, den_s;
    logic [SW-1:0]        sum_x, sum_y;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign is_load  = accept && (s_tuser == REQ_LOAD);
    assign is_step  = accept && (s_tuser == REQ_STEP);

    // endpoint fields and swap so that y walks upward
    always_comb
    begin
        ex = s_tdata[W-1:0];
        ey = s_tdata[2*W-1:W];
        sx = s_tdata[3*W-1:2*W];
        sy = s_tdata[4*W-1:3*W];
        ld_inv = (ey < sy);
        tx = ld_inv ? sx : ex;
        ty = ld_inv ? sy : ey;
        ox = ld_inv ? ex : sx;
        oy = ld_inv ? ey : sy;
        ld_rising = (tx >= ox);
        diff_x = {tx[W-1], tx} - {ox[W-1], ox};
        ld_dx  = ld_rising ? diff_x : -diff_x;
        ld_dy  = {ty[W-1], ty} - {oy[W-1], oy};
        ld_major = (ld_dx >= ld_dy);
        dx_e = {{2{ld_dx[W]}}, ld_dx};
        dy_e = {{2{ld_dy[W]}}, ld_dy};
        dx2  = {dx_e[DW-2:0], 1'b0};
        dy2  = {dy_e[DW-2:0], 1'b0};
        if (ld_major)
        begin
            ld_dec = dy2 - dx_e;
            ld_se  = dy2;
            ld_sne = dy2 - dx2;
        end
        else
        begin
            ld_dec = dx2 - dy_e;
            ld_se  = dx2;
            ld_sne = dx2 - dy2;
        end
    end

    // one walk or tail step
    always_comb
    begin
        walk    = (cur_x_reg != tgt_x_reg);
        tail    = !walk && (cur_y_reg != tgt_y_reg);
        dec_le0 = dec_reg[DW-1] || (dec_reg == '0);
        xstep   = x_rising_reg ? W'(1) : '1;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        dec_next   = dec_reg;
        num_s      = {cur_y_reg[W-1], cur_y_reg} - {tgt_y_reg[W-1], tgt_y_reg};
        den_s      = {org_y_reg[W-1], org_y_reg} - {tgt_y_reg[W-1], tgt_y_reg};
        if (walk)
        begin
            if (dec_le0)
            begin
                dec_next = dec_reg + step_e_reg;
                if (x_major_reg)
                begin
                    cur_x_next = cur_x_reg + xstep;
                end
                else
                begin
                    cur_y_next = cur_y_reg + W'(1);
                end
            end
            else
            begin
                dec_next   = dec_reg + step_ne_reg;
                cur_x_next = cur_x_reg + xstep;
                cur_y_next = cur_y_reg + W'(1);
            end
            num_s = {cur_x_next[W-1], cur_x_next} - {tgt_x_reg[W-1], tgt_x_reg};
            den_s = {org_x_reg[W-1], org_x_reg} - {tgt_x_reg[W-1], tgt_x_reg};
        end
        else if (tail)
        begin
            cur_y_next = cur_y_reg + W'(1);
        end
    end

    // pixel with offsets added, progress operands as magnitudes
    always_comb
    begin
        sum_x = {{(SW-W){cur_x_next[W-1]}}, cur_x_next}
              + {{(SW-REG_WIDTH){h_off_reg[REG_WIDTH-1]}}, h_off_reg};
        sum_y = {{(SW-W){cur_y_next[W-1]}}, cur_y_next}
              + {{(SW-REG_WIDTH){v_off_reg[REG_WIDTH-1]}}, v_off_reg};
        push           = is_step;
        ctrl.pix_valid = walk || tail;
        ctrl.zero_q    = (den_s == '0) || (num_s == '0) || (num_s[W] != den_s[W]);
        ctrl.inv       = inv_reg;
        ctrl.done      = (cur_x_next == tgt_x_reg) && (cur_y_next == tgt_y_reg);
        num_mag        = num_s[W] ? -num_s : num_s;
        den_mag        = den_s[W] ? -den_s : den_s;
        if (walk || tail)
        begin
            px = sum_x[PIX_WIDTH-1:0];
            py = sum_y[PIX_WIDTH-1:0];
        end
        else
        begin
            px = '0;
            py = '0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_off_reg <= '0;
            v_off_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_H_OFFSET: h_off_reg <= cfg_data;
                CFG_V_OFFSET: v_off_reg <= cfg_data;
                default:      h_off_reg <= h_off_reg;
            endcase
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            tgt_x_reg    <= '0;
            tgt_y_reg    <= '0;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            dec_reg      <= '0;
            step_e_reg   <= '0;
            step_ne_reg  <= '0;
            x_major_reg  <= 1'b0;
            x_rising_reg <= 1'b0;
            inv_reg      <= 1'b0;
        end
        else if (is_load)
        begin
            cur_x_reg    <= ox;
            cur_y_reg    <= oy;
            tgt_x_reg    <= tx;
            tgt_y_reg    <= ty;
            org_x_reg    <= ox;
            org_y_reg    <= oy;
            dec_reg      <= ld_dec;
            step_e_reg   <= ld_se;
            step_ne_reg  <= ld_sne;
            x_major_reg  <= ld_major;
            x_rising_reg <= ld_rising;
            inv_reg      <= ld_inv;
        end
        else if (is_step)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            dec_reg   <= dec_next;
        end
    end

endmodule

>>> rtl/core/lrg_back.sv
module lrg_back
    import lrg_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  lrg_ctrl_t              q_ctrl,
    input  logic [PIX_WIDTH-1:0]   q_px,
    input  logic [PIX_WIDTH-1:0]   q_py,
    input  logic [W:0]             q_num_mag,
    input  logic [W:0]             q_den_mag,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    // dividend width: magnitude times 100
    localparam int NW = W + 7;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

    state_t               state_reg, state_next;
    lrg_ctrl_t            ctrl_reg, ctrl_next;
    logic [PIX_WIDTH-1:0] px_reg, px_next, py_reg, py_next;
    logic [W:0]           den_reg, den_next;
    logic [W:0]           rem_reg, rem_next;
    logic [NW-1:0]        dvd_reg, dvd_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 ov_reg, ov_next;
    logic [PIX_WIDTH-1:0] opx_reg, opx_next, opy_reg, opy_next;
    logic [PCT_WIDTH-1:0] pct_reg, pct_next;
    logic                 opv_reg, opv_next, odone_reg, odone_next;

    logic [W+1:0]         trial;
    logic                 ge;
    logic [W+1:0]         trial_sub;
    logic [PCT_WIDTH-1:0] q_clamp, pct_val;

    // one restoring division step and percent finish
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[NW-1]};
        ge        = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
        if (ctrl_reg.zero_q)
        begin
            q_clamp = '0;
        end
        else if (dvd_reg > NW'(PCT_FULL))
        begin
            q_clamp = PCT_FULL;
        end
        else
        begin
            q_clamp = dvd_reg[PCT_WIDTH-1:0];
        end
        if (!ctrl_reg.pix_valid)
        begin
            pct_val = '0;
        end
        else if (ctrl_reg.inv)
        begin
            pct_val = PCT_FULL - q_clamp;
        end
        else
        begin
            pct_val = q_clamp;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        ctrl_next  = ctrl_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !m_tready;
        opx_next   = opx_reg;
        opy_next   = opy_reg;
        pct_next   = pct_reg;
        opv_next   = opv_reg;
        odone_next = odone_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    ctrl_next  = q_ctrl;
                    px_next    = q_px;
                    py_next    = q_py;
                    den_next   = q_den_mag;
                    rem_next   = '0;
                    dvd_next   = NW'(q_num_mag) * NW'(PCT_FULL);
                    cnt_next   = CW'(NW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? trial_sub[W:0] : trial[W:0];
                dvd_next = {dvd_reg[NW-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    opx_next   = px_reg;
                    opy_next   = py_reg;
                    pct_next   = pct_val;
                    opv_next   = ctrl_reg.pix_valid;
                    odone_next = ctrl_reg.done;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctrl_reg  <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            opx_reg   <= '0;
            opy_reg   <= '0;
            pct_reg   <= '0;
            opv_reg   <= 1'b0;
            odone_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctrl_reg  <= ctrl_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            den_reg   <= den_next;
            rem_reg   <= rem_next;
            dvd_reg   <= dvd_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            opx_reg   <= opx_next;
            opy_reg   <= opy_next;
            pct_reg   <= pct_next;
            opv_reg   <= opv_next;
            odone_reg <= odone_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, pct_reg, opy_reg, opx_reg};
    assign m_tuser  = opv_reg;
    assign m_tlast  = odone_reg;

endmodule

>>> rtl/core/line_rasterizer_with_gradient.sv
// Line rasterizer with progress gradient.
// Input stream (s_*): s_tuser selects the request, 0 loads a line from the
// four endpoint coordinates in s_tdata, 1 asks for the next pixel. A load
// produces no output; each pixel request produces exactly one transaction.
// Output stream (m_*): pixel x and y with the offsets added, a 0..100
// progress value, m_tuser set when a pixel is carried, m_tlast set when the
// line has no pixel left. A request after the end gives an empty, last beat.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 h_offset,
// 1 v_offset); write only while the block is idle.
// Flow: a load and a walk step each update the walk registers on acceptance,
// and the step's pixel enters a two-entry queue. The percent divider is a
// restoring divider at one quotient bit per cycle over COORD_WIDTH + 7 bits;
// the back divides one queued pixel at a time and takes the next only once
// the previous beat is in the output register, while the front accepts
// requests as long as the queue has room.
// Reset clears the walk state and offsets to zero; a pixel request right
// after reset returns the empty, last beat. When m_tready is low the output
// beat holds, the divider waits, the queue fills and s_tready drops.
module line_rasterizer_with_gradient
    import lrg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // end_x, end_y, start_x, start_y, zero pad
    input  logic [IN_TDATA_W-1:0]    s_tdata,
    // req_type
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pixel_x, pixel_y, percent, zero pad
    output logic [OUT_TDATA_W-1:0]   m_tdata,
    // pixel_valid
    output logic                     m_tuser,
    // line_done
    output logic                     m_tlast,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [REG_WIDTH-1:0]     cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int QW = $bits(lrg_ctrl_t) + 2 * PIX_WIDTH + 2 * (W + 1);

    logic                 push, pop, q_full, q_empty;
    lrg_ctrl_t            f_ctrl, q_ctrl;
    logic [PIX_WIDTH-1:0] f_px, f_py, q_px, q_py;
    logic [W:0]           f_num, f_den, q_num, q_den;
    logic [QW-1:0]        q_wr, q_rd;

    // front: accepts requests, walks the line
    lrg_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .ctrl      (f_ctrl),
        .px        (f_px),
        .py        (f_py),
        .num_mag   (f_num),
        .den_mag   (f_den)
    );

    // queue between walk and divider
    assign q_wr = {f_ctrl, f_px, f_py, f_num, f_den};
    assign {q_ctrl, q_px, q_py, q_num, q_den} = q_rd;

    lrg_queue #(.WIDTH(QW)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr),
        .pop     (pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    // back: percent division and output register
    lrg_back #(.W(W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_ctrl    (q_ctrl),
        .q_px      (q_px),
        .q_py      (q_py),
        .q_num_mag (q_num),
        .q_den_mag (q_den),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef ASSERT_OFF
    // an empty beat always closes the line with zero progress
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            m_tlast && (m_tdata[2*PIX_WIDTH +: PCT_WIDTH] == '0))
        else $error("empty beat without line_done or with nonzero percent");

    // progress never exceeds full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*PIX_WIDTH +: PCT_WIDTH] <= PCT_FULL))
        else $error("percent above full scale");

    // queue status is consistent and full stops input
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty && !s_tready)
        else $error("queue flags inconsistent with s_tready");

    // the divider only takes entries that exist
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");
`endif

endmodule

>>> verif/line_pixel_checker.sv
`timescale 1ns / 1ps

module line_pixel_checker
    import lrg_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    localparam int LINE_W = ((4 * CW + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // end_x, end_y, start_x, start_y, zero pad
    input  logic [LINE_W-1:0]      s_tdata,
    // req_type
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // pixel_x, pixel_y, percent, zero pad
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    // pixel_valid
    input  logic                   m_tuser,
    // line_done
    input  logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [REG_WIDTH-1:0]   cfg_data,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic                 has_pixel;
        logic [PIX_WIDTH-1:0] px;
        logic [PIX_WIDTH-1:0] py;
        logic [PCT_WIDTH-1:0] pct;
        logic                 last;
    } pixel_beat_t;

    // pixels predicted but not yet seen on the output
    pixel_beat_t beats_due[$];

    // walk state mirrored from the line commands
    logic signed [CW-1:0]        walk_x, walk_y, goal_x, goal_y, home_x, home_y;
    logic signed [CW+2:0]        err_acc, err_e, err_ne;
    logic                        x_major, x_up, swapped;
    logic signed [REG_WIDTH-1:0] off_h, off_v;

    // progress ramp: truncating divide, clamped, reversed for swapped lines
    function automatic logic [PCT_WIDTH-1:0] ramp_pct(int num, int den, logic flip);
        int q;
        q = 0;
        if (den != 0)
            q = (num * int'(PCT_FULL)) / den;
        if (q < 0)
            q = 0;
        if (q > int'(PCT_FULL))
            q = int'(PCT_FULL);
        if (flip)
            q = int'(PCT_FULL) - q;
        return q[PCT_WIDTH-1:0];
    endfunction

    // readable form of one beat
    function automatic string beat_str(pixel_beat_t b);
        return $sformatf("valid=%0b x=%0d y=%0d pct=%0d last=%0b",
                         b.has_pixel, $signed(b.px), $signed(b.py), b.pct, b.last);
    endfunction

    // set up a new walk, always running upward in y
    task automatic load_line(input logic [LINE_W-1:0] d);
        int ex, ey, sx, sy, t, dx, dy;
        ex = int'($signed(d[CW-1:0]));
        ey = int'($signed(d[2*CW-1:CW]));
        sx = int'($signed(d[3*CW-1:2*CW]));
        sy = int'($signed(d[4*CW-1:3*CW]));
        swapped = (ey < sy);
        if (swapped)
        begin
            t = ex; ex = sx; sx = t;
            t = ey; ey = sy; sy = t;
        end
        goal_x = CW'(ex);
        goal_y = CW'(ey);
        home_x = CW'(sx);
        home_y = CW'(sy);
        x_up = (ex >= sx);
        dx = x_up ? ex - sx : sx - ex;
        dy = ey - sy;
        x_major = (dx >= dy);
        if (x_major)
        begin
            err_acc = (CW+3)'(2 * dy - dx);
            err_e   = (CW+3)'(2 * dy);
            err_ne  = (CW+3)'(2 * (dy - dx));
        end
        else
        begin
            err_acc = (CW+3)'(2 * dx - dy);
            err_e   = (CW+3)'(2 * dx);
            err_ne  = (CW+3)'(2 * (dx - dy));
        end
        walk_x = CW'(sx);
        walk_y = CW'(sy);
    endtask

    // advance the walk by one pixel and build the beat it should emit
    task automatic step_line(output pixel_beat_t beat);
        beat = '0;
        if (walk_x != goal_x)
        begin
            if (err_acc <= 0)
            begin
                err_acc = err_acc + err_e;
                if (x_major)
                    walk_x = x_up ? walk_x + CW'(1) : walk_x - CW'(1);
                else
                    walk_y = walk_y + CW'(1);
            end
            else
            begin
                err_acc = err_acc + err_ne;
                walk_y = walk_y + CW'(1);
                walk_x = x_up ? walk_x + CW'(1) : walk_x - CW'(1);
            end
            beat.pct = ramp_pct(int'(walk_x) - int'(goal_x),
                                int'(home_x) - int'(goal_x), swapped);
            beat.has_pixel = 1'b1;
        end
        else if (walk_y != goal_y)
        begin
            // vertical tail, percent taken before the move
            beat.pct = ramp_pct(int'(walk_y) - int'(goal_y),
                                int'(home_y) - int'(goal_y), swapped);
            walk_y = walk_y + CW'(1);
            beat.has_pixel = 1'b1;
        end
        if (beat.has_pixel)
        begin
            beat.px   = PIX_WIDTH'(int'(walk_x) + int'(off_h));
            beat.py   = PIX_WIDTH'(int'(walk_y) + int'(off_v));
            beat.last = (walk_x == goal_x) && (walk_y == goal_y);
        end
        else
        begin
            // nothing left: empty beat flagged as last
            beat.last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_beat_t got, want, pred;
        if (!rst_n)
        begin
            beats_due.delete();
            errors  = 0;
            pending = 0;
            walk_x = '0; walk_y = '0; goal_x = '0; goal_y = '0;
            home_x = '0; home_y = '0;
            err_acc = '0; err_e = '0; err_ne = '0;
            x_major = 1'b0; x_up = 1'b0; swapped = 1'b0;
            off_h = '0; off_v = '0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_H_OFFSET: off_h = cfg_data;
                    CFG_V_OFFSET: off_v = cfg_data;
                    default: ;
                endcase
            end

            // output transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.has_pixel = m_tuser;
                got.px        = m_tdata[PIX_WIDTH-1:0];
                got.py        = m_tdata[2*PIX_WIDTH-1:PIX_WIDTH];
                got.pct       = m_tdata[2*PIX_WIDTH+PCT_WIDTH-1:2*PIX_WIDTH];
                got.last      = m_tlast;
                if (beats_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output transaction: %s", beat_str(got));
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (got.has_pixel != want.has_pixel || got.px != want.px ||
                        got.py != want.py || got.pct != want.pct || got.last != want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("pixel mismatch: expected %s, got %s",
                                     beat_str(want), beat_str(got));
                    end
                end
            end

            // input transaction updates the walk
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_STEP)
                begin
                    step_line(pred);
                    beats_due.push_back(pred);
                end
                else
                begin
                    load_line(s_tdata);
                end
            end
            pending = beats_due.size();
        end
    end

endmodule

>>> verif/line_rasterizer_with_gradient_tb.sv
`timescale 1ns / 1ps

module line_rasterizer_with_gradient_tb;
    import lrg_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int LINE_W      = ((4 * CW + 7) / 8) * 8;
    localparam int SETTLE      = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 200;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [LINE_W-1:0]        s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [REG_WIDTH-1:0]     cfg_data;

    int check_errors;
    int beats_pending;
    int sent;
    int burst_left;
    // toggled by the stimulus to ask the receiver for one long hold-off
    bit hold_req;

    line_rasterizer_with_gradient dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_pixel_checker #(.CW(CW)) pixel_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (check_errors),
        .pending   (beats_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("line_rasterizer_with_gradient verification failed");
        $finish;
    end

    function automatic int rand_coord();
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    function automatic int edge_coord();
        int v;
        if ($urandom_range(0, 1))
            v = 4095 - int'($urandom_range(0, 3));
        else
            v = -4096 + int'($urandom_range(0, 3));
        return v;
    endfunction

    function automatic int clamp_coord(int v);
        return (v > 4095) ? 4095 : ((v < -4096) ? -4096 : v);
    endfunction

    function automatic logic [LINE_W-1:0] line_word(int ex, int ey, int sx, int sy);
        logic [LINE_W-1:0] w;
        w = '0;
        w[CW-1:0]      = ex[CW-1:0];
        w[2*CW-1:CW]   = ey[CW-1:0];
        w[3*CW-1:2*CW] = sx[CW-1:0];
        w[4*CW-1:3*CW] = sy[CW-1:0];
        return w;
    endfunction

    // one input transaction; sender works in bursts separated by random gaps
    task automatic send_req(input logic kind, input logic [LINE_W-1:0] payload);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 9));
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // load a line, then ask for some pixels with junk in the unused payload
    task automatic line_then_steps(input int ex, input int ey, input int sx, input int sy,
                                   input int steps);
        send_req(REQ_LOAD, line_word(ex, ey, sx, sy));
        repeat (steps)
            send_req(REQ_STEP, line_word(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
    endtask

    // stop offering and wait for every pixel to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (beats_pending == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_offsets(input int h, input int v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_H_OFFSET;
        cfg_data  <= h[REG_WIDTH-1:0];
        @(negedge clk);
        cfg_index <= CFG_V_OFFSET;
        cfg_data  <= v[REG_WIDTH-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random lines: mostly complete walks, some cut short or overrun, some long
    task automatic run_lines(input int quota, input bit hold_midway);
        int start_cnt, ex, ey, sx, sy, ax, ay, span, steps, reach;
        start_cnt = sent;
        while (sent - start_cnt < quota)
        begin
            reach = ($urandom_range(0, 5) == 0) ? 60 : 12;
            sx = ($urandom_range(0, 3) == 0) ? edge_coord() : rand_coord();
            sy = ($urandom_range(0, 3) == 0) ? edge_coord() : rand_coord();
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
            if ($urandom_range(0, 9) == 0)
            begin
                ex = rand_coord();
                ey = rand_coord();
            end
            ax = (ex > sx) ? ex - sx : sx - ex;
            ay = (ey > sy) ? ey - sy : sy - ey;
            span = (ax > ay) ? ax : ay;
            if (span > 2 * reach)
                steps = $urandom_range(0, 6);
            else if ($urandom_range(0, 4) == 0)
                steps = $urandom_range(0, span);
            else
                steps = span + int'($urandom_range(0, 2));
            if (hold_midway && sent - start_cnt >= quota / 2)
            begin
                // receiver goes quiet while we keep pushing pixel requests
                hold_req = ~hold_req;
                hold_midway = 1'b0;
            end
            line_then_steps(ex, ey, sx, sy, steps);
        end
    endtask

    // receiver: own stall pattern plus one long hold-off on request
    initial
    begin
        int mode, left, tick;
        bit hold_seen;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 60);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int h, v;
        s_tvalid   = 1'b0;
        s_tuser    = REQ_LOAD;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_H_OFFSET;
        cfg_data   = '0;
        rst_n      = 1'b0;
        sent       = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pixel request straight out of reset gives the empty last beat
        send_req(REQ_STEP, line_word(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
        drain();
        set_offsets(4095, -4096);

        // single point: nothing to draw
        line_then_steps(5, 5, 5, 5, 1);
        // horizontal, run past the end
        line_then_steps(2, 0, 0, 0, 3);
        // vertical: tail only
        line_then_steps(0, 2, 0, 0, 2);
        // end below start: swapped, x falling, y-major
        line_then_steps(4, -10, 3, -7, 4);
        // full-range diagonal
        line_then_steps(4095, 4095, -4096, -4096, 2);
        // full-range, swapped and x falling
        line_then_steps(4095, -4096, -4096, 4095, 2);
        // shallow x-major falling, reloaded mid-line
        line_then_steps(-3, 1, 2, 0, 2);
        drain();

        // random phases under different offsets
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    h = -4096;
                    v = 4095;
                end
                1:
                begin
                    h = 0;
                    v = 0;
                end
                3:
                begin
                    h = 4095;
                    v = 4095;
                end
                4:
                begin
                    h = -4096;
                    v = -4096;
                end
                6:
                begin
                    h = 4095;
                    v = -4096;
                end
                default:
                begin
                    h = rand_coord();
                    v = rand_coord();
                end
            endcase
            set_offsets(h, v);
            run_lines(PHASE_ITEMS, p == 1);
            drain();
        end

        if (check_errors == 0 && beats_pending == 0)
            $display("line_rasterizer_with_gradient verification clean");
        else
            $display("line_rasterizer_with_gradient verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lrg_pkg.sv
rtl/core/lrg_queue.sv
rtl/core/lrg_front.sv
rtl/core/lrg_back.sv
rtl/core/line_rasterizer_with_gradient.sv
verif/line_pixel_checker.sv
verif/line_rasterizer_with_gradient_tb.sv
